// ----- design/text_console_cursor_writer_assert.svh -----
// assertion macros for the text console cursor writer checker
`ifndef TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define TCCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccw check failed");

// consequent must hold in the same cycle as the antecedent
`define TCCW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccw check failed");

`endif

// ----- design/tccw_pkg.sv -----
// shared types and constants of the text console cursor writer
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned COUNT_W    = 3;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [COUNT_W-1:0] MAX_WRITES = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_NEWLINE,
    OP_RETURN,
    OP_WRITE
  } cursor_op_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] tab_spaces;
  } cursor_status_t;

endpackage

// ----- design/tccw_cursor.sv -----
// cursor position registers and the shared index adder
`timescale 1ns / 1ps

module tccw_cursor #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tccw_pkg::cursor_op_t     op,
  output tccw_pkg::cursor_status_t status
);

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PH_W   = $clog2(TAB_STOP);
  localparam int unsigned BASE_W = $clog2(ROWS * COLUMNS + 1);
  localparam int unsigned SPACE_W = PH_W + 1;
  localparam int unsigned CMP_W  = (SPACE_W > tccw_pkg::COUNT_W) ? SPACE_W : tccw_pkg::COUNT_W;

  logic [COL_W-1:0]  column, column_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [PH_W-1:0]   phase, phase_next;
  logic [BASE_W-1:0] base, base_next;
  logic [BASE_W-1:0] index_full;
  logic [SPACE_W-1:0] spaces;
  logic              advance;

  // base holds row * COLUMNS so the index is one add
  assign index_full = base + BASE_W'(column);
  assign spaces     = SPACE_W'(TAB_STOP) - SPACE_W'(phase);

  always_comb begin
    status.index = tccw_pkg::INDEX_W'(index_full);
    if (CMP_W'(spaces) > CMP_W'(tccw_pkg::MAX_WRITES)) begin
      status.tab_spaces = tccw_pkg::MAX_WRITES;
    end else begin
      status.tab_spaces = tccw_pkg::COUNT_W'(spaces);
    end
  end

  always_comb begin
    column_next = column;
    phase_next  = phase;
    advance     = 1'b0;
    unique case (op)
      tccw_pkg::OP_NONE: begin
      end
      tccw_pkg::OP_NEWLINE: begin
        column_next = '0;
        phase_next  = '0;
        advance     = 1'b1;
      end
      tccw_pkg::OP_RETURN: begin
        column_next = '0;
        phase_next  = '0;
      end
      tccw_pkg::OP_WRITE: begin
        if (column == COL_W'(COLUMNS - 1)) begin
          column_next = '0;
          phase_next  = '0;
          advance     = 1'b1;
        end else begin
          column_next = column + 1'b1;
          phase_next  = (phase == PH_W'(TAB_STOP - 1)) ? '0 : phase + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row_next  = row;
    base_next = base;
    if (advance) begin
      if (row == ROW_W'(ROWS - 1)) begin
        row_next  = '0;
        base_next = '0;
      end else begin
        row_next  = row + 1'b1;
        base_next = base + BASE_W'(COLUMNS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      phase  <= '0;
      base   <= '0;
    end else begin
      column <= column_next;
      row    <= row_next;
      phase  <= phase_next;
      base   <= base_next;
    end
  end

endmodule

// ----- design/tccw_seq.sv -----
// character decode, write sequencer and output register
`timescale 1ns / 1ps

module tccw_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 character_valid,
  input  logic [tccw_pkg::CHAR_W-1:0]          character,
  output logic                                 character_ready,
  input  logic [tccw_pkg::CHAR_W-1:0]          attr,
  input  tccw_pkg::cursor_status_t             status,
  output tccw_pkg::cursor_op_t                 op,
  output logic                                 cell_valid,
  input  logic                                 cell_ready,
  output logic [tccw_pkg::INDEX_W-1:0]         cell_index,
  output logic [tccw_pkg::WORD_W-1:0]          cell_word,
  output logic                                 last_write
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t                        state;
  logic [tccw_pkg::COUNT_W-1:0]  remaining;
  logic [tccw_pkg::CHAR_W-1:0]   code;
  logic                          accept;
  logic                          slot_free;

  assign character_ready = (state == IDLE);
  assign accept          = character_valid && character_ready;
  assign slot_free       = !cell_valid || cell_ready;

  always_comb begin
    op = tccw_pkg::OP_NONE;
    if (state == EMIT) begin
      if (slot_free) begin
        op = tccw_pkg::OP_WRITE;
      end
    end else if (accept) begin
      if (character == tccw_pkg::CH_NEWLINE) begin
        op = tccw_pkg::OP_NEWLINE;
      end else if (character == tccw_pkg::CH_RETURN) begin
        op = tccw_pkg::OP_RETURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cell_valid <= 1'b0;
      remaining  <= '0;
    end else begin
      // in EMIT a taken write is always replaced by the next one
      if (cell_valid && cell_ready && state != EMIT) begin
        cell_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (character == tccw_pkg::CH_TAB) begin
              state     <= EMIT;
              remaining <= status.tab_spaces;
              code      <= tccw_pkg::CH_SPACE;
            end else if (character != tccw_pkg::CH_NEWLINE &&
                         character != tccw_pkg::CH_RETURN) begin
              state     <= EMIT;
              remaining <= tccw_pkg::COUNT_W'(1);
              code      <= character;
            end
          end
        end
        EMIT: begin
          if (slot_free) begin
            cell_valid <= 1'b1;
            cell_index <= status.index;
            cell_word  <= {attr, code};
            last_write <= (remaining == tccw_pkg::COUNT_W'(1));
            remaining  <= remaining - 1'b1;
            if (remaining == tccw_pkg::COUNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/text_console_cursor_writer.sv -----
// Text console cursor writer: takes one character byte per item and emits the
// cell writes it causes on a COLUMNS x ROWS screen. Any byte but tab, newline
// and return gives one write out of the output register; a tab gives one write
// per space (one to four); newline and return emit nothing. A tab's writes
// leave one a cycle through the single output register while cell_ready is
// high; a stalled cell_ready holds the sequencer. The cell index comes from
// one adder over a running row base and the column; no multiplier.
`timescale 1ns / 1ps

module text_console_cursor_writer #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tccw_pkg::CHAR_W-1:0]  cfg_data,
  input  logic                         character_valid,
  output logic                         character_ready,
  input  logic [tccw_pkg::CHAR_W-1:0]  character,
  output logic                         cell_valid,
  input  logic                         cell_ready,
  output logic [tccw_pkg::INDEX_W-1:0] cell_index,
  output logic [tccw_pkg::WORD_W-1:0]  cell_word,
  output logic                         last_write
);

  logic [tccw_pkg::CHAR_W-1:0] text_attribute;
  tccw_pkg::cursor_op_t        op;
  tccw_pkg::cursor_status_t    status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccw_pkg::ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  tccw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .status (status)
  );

  tccw_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .character_valid (character_valid),
    .character       (character),
    .character_ready (character_ready),
    .attr            (text_attribute),
    .status          (status),
    .op              (op),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .cell_index      (cell_index),
    .cell_word       (cell_word),
    .last_write      (last_write)
  );

endmodule

// ----- design/tccw_chk.sv -----
// port checker for the text console cursor writer and its bind
`timescale 1ns / 1ps
`include "text_console_cursor_writer_assert.svh"

module tccw_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         character_valid,
  input logic                         character_ready,
  input logic [tccw_pkg::CHAR_W-1:0]  character,
  input logic                         cell_valid,
  input logic                         cell_ready,
  input logic [tccw_pkg::INDEX_W-1:0] cell_index,
  input logic [tccw_pkg::WORD_W-1:0]  cell_word,
  input logic                         last_write
);

  logic char_take;
  logic cell_take;

  assign char_take = character_valid && character_ready;
  assign cell_take = cell_valid && cell_ready;

  // a stalled result holds its payload
  `TCCW_ASSERT_NEXT(a_cell_hold, cell_valid && !cell_ready,
    cell_valid && $stable(cell_index) && $stable(cell_word) && $stable(last_write))

  // a byte that writes keeps the input closed until its last write is in the output register
  `TCCW_ASSERT_NEXT(a_busy_after_write_item,
    char_take && character != tccw_pkg::CH_NEWLINE && character != tccw_pkg::CH_RETURN,
    !character_ready)

  // more writes of the same item still to come
  `TCCW_ASSERT_NEXT(a_busy_until_last, cell_take && !last_write, cell_valid)

  // only a tab gives several writes, and those are spaces
  `TCCW_ASSERT_SAME(a_early_write_is_space, cell_valid && !last_write,
    cell_word[7:0] == tccw_pkg::CH_SPACE)

endmodule

bind text_console_cursor_writer tccw_chk u_tccw_chk (.*);

// ----- tb/tb_text_console_cursor_writer.sv -----
// testbench for the text console cursor writer: a directed opening, then random text
`timescale 1ns / 1ps

module tb_text_console_cursor_writer;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_STOP   = 4;
  localparam int unsigned QUIET_MAX  = 1000;
  localparam int unsigned DRAIN_WAIT = 10;

  typedef struct packed {
    logic [tccw_pkg::INDEX_W-1:0] index;
    logic [tccw_pkg::WORD_W-1:0]  word;
    logic                         last;
  } cell_write_t;

  typedef struct packed {
    logic [tccw_pkg::CHAR_W-1:0] ch;
    logic                        typed;
    cell_write_t                 due;
  } script_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tccw_pkg::CHAR_W-1:0]   cfg_data;
  logic                          character_valid;
  logic                          character_ready;
  logic [tccw_pkg::CHAR_W-1:0]   character;
  logic                          cell_valid;
  logic                          cell_ready;
  logic [tccw_pkg::INDEX_W-1:0]  cell_index;
  logic [tccw_pkg::WORD_W-1:0]   cell_word;
  logic                          last_write;

  // predicted cursor and attribute
  logic [4:0]                    cur_row;
  logic [6:0]                    cur_col;
  logic [tccw_pkg::CHAR_W-1:0]   attr_now;
  cell_write_t                   cells_due [$];
  cell_write_t                   seen_due;
  int                            mismatches;
  int                            chars_sent;
  int                            quiet_cycles;
  bit                            stalls_on;

  // opening text from reset, attribute still at its reset value
  script_row_t opening_script [22] = '{
    '{8'h41,                1'b1, '{11'd0, 16'h0741, 1'b1}},
    '{8'h00,                1'b1, '{11'd1, 16'h0700, 1'b1}},
    '{8'hff,                1'b1, '{11'd2, 16'h07ff, 1'b1}},
    '{tccw_pkg::CH_TAB,     1'b1, '{11'd3, 16'h0720, 1'b1}},
    '{tccw_pkg::CH_TAB,     1'b0, '0},
    '{8'h7e,                1'b0, '0},
    '{tccw_pkg::CH_TAB,     1'b0, '0},
    '{tccw_pkg::CH_RETURN,  1'b0, '0},
    '{8'h20,                1'b1, '{11'd0, 16'h0720, 1'b1}},
    '{tccw_pkg::CH_NEWLINE, 1'b0, '0},
    '{tccw_pkg::CH_TAB,     1'b0, '0},
    '{8'h08,                1'b0, '0},
    '{8'h0b,                1'b0, '0},
    '{8'h0c,                1'b0, '0},
    '{8'h0e,                1'b0, '0},
    '{8'h80,                1'b0, '0},
    '{tccw_pkg::CH_NEWLINE, 1'b0, '0},
    '{tccw_pkg::CH_NEWLINE, 1'b0, '0},
    '{8'h7f,                1'b0, '0},
    '{tccw_pkg::CH_TAB,     1'b0, '0},
    '{tccw_pkg::CH_RETURN,  1'b0, '0},
    '{tccw_pkg::CH_TAB,     1'b0, '0}
  };

  text_console_cursor_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .character_valid (character_valid),
    .character_ready (character_ready),
    .character       (character),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .cell_index      (cell_index),
    .cell_word       (cell_word),
    .last_write      (last_write)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void next_row();
    if (cur_row == ROWS - 1) cur_row = '0;
    else cur_row = cur_row + 1'b1;
  endfunction

  function automatic void place_cell(input logic [tccw_pkg::CHAR_W-1:0] code, input logic last);
    int unsigned idx;
    cell_write_t w;
    idx = cur_row * COLUMNS + cur_col;
    w.index = idx[tccw_pkg::INDEX_W-1:0];
    w.word  = {attr_now, code};
    w.last  = last;
    cells_due.push_back(w);
    if (cur_col == COLUMNS - 1) begin
      cur_col = '0;
      next_row();
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  // cursor movement and cell writes caused by one character
  function automatic void predict_char(input logic [tccw_pkg::CHAR_W-1:0] ch);
    int spaces;
    case (ch)
      tccw_pkg::CH_NEWLINE: begin
        cur_col = '0;
        next_row();
      end
      tccw_pkg::CH_RETURN: begin
        cur_col = '0;
      end
      tccw_pkg::CH_TAB: begin
        spaces = TAB_STOP - (cur_col % TAB_STOP);
        if (spaces > tccw_pkg::MAX_WRITES) spaces = tccw_pkg::MAX_WRITES;
        for (int k = 0; k < spaces; k++) place_cell(tccw_pkg::CH_SPACE, k == spaces - 1);
      end
      default: begin
        place_cell(ch, 1'b1);
      end
    endcase
  endfunction

  // entered and left at a falling edge; valid stays up after acceptance
  task automatic send_char(input logic [tccw_pkg::CHAR_W-1:0] ch, input bit has_typed = 1'b0,
                           input cell_write_t typed = '0);
    while (stalls_on && $urandom_range(99) < 33) begin
      character_valid <= 1'b0;
      @(negedge clk);
    end
    character       <= ch;
    character_valid <= 1'b1;
    do @(posedge clk); while (!character_ready);
    predict_char(ch);
    if (has_typed) begin
      void'(cells_due.pop_back());
      cells_due.push_back(typed);
    end
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic write_attr(input logic [tccw_pkg::CHAR_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    attr_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    character_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [tccw_pkg::CHAR_W-1:0] text_byte();
    if ($urandom_range(5) == 0) return tccw_pkg::CH_TAB;
    return tccw_pkg::CHAR_W'($urandom_range(32, 126));
  endfunction

  // lines of text, some longer than a row, blank lines and raw noise bytes
  task automatic run_text(input int budget);
    int start;
    int kind;
    int len;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      kind = $urandom_range(9);
      if (kind < 6) begin
        len = (kind == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        repeat (len) send_char(text_byte());
        send_char(($urandom_range(3) == 0) ? tccw_pkg::CH_RETURN : tccw_pkg::CH_NEWLINE);
      end else if (kind == 9) begin
        repeat ($urandom_range(1, 6)) send_char(tccw_pkg::CH_NEWLINE);
      end else begin
        repeat ($urandom_range(1, 8)) send_char(tccw_pkg::CHAR_W'($urandom_range(255)));
      end
    end
  endtask

  always @(negedge clk) begin
    cell_ready <= !stalls_on || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (!rst && cell_valid && cell_ready) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell write index %0d word %h last %b",
                 $time, cell_index, cell_word, last_write);
        mismatches++;
      end else begin
        seen_due = cells_due.pop_front();
        if (cell_index !== seen_due.index) begin
          $display("%0t: cell_index expected %0d got %0d", $time, seen_due.index, cell_index);
          mismatches++;
        end
        if (cell_word !== seen_due.word) begin
          $display("%0t: cell_word expected %h got %h", $time, seen_due.word, cell_word);
          mismatches++;
        end
        if (last_write !== seen_due.last) begin
          $display("%0t: last_write expected %b got %b", $time, seen_due.last, last_write);
          mismatches++;
        end
      end
    end
  end

  // ends a hung run: counts cycles with no item moving on any channel
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (character_valid && character_ready) ||
        (cell_valid && cell_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("** text_console_cursor_writer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    character_valid = 1'b0;
    character       = '0;
    cell_ready      = 1'b0;
    cur_row         = '0;
    cur_col         = '0;
    attr_now        = tccw_pkg::ATTR_RESET;
    mismatches      = 0;
    chars_sent      = 0;
    quiet_cycles    = 0;
    stalls_on       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_script[i])
      send_char(opening_script[i].ch, opening_script[i].typed, opening_script[i].due);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_attr(8'h00);
        1:       write_attr(8'hff);
        default: write_attr(tccw_pkg::CHAR_W'($urandom_range(255)));
      endcase
      stalls_on = (phase != 2);
      run_text(35);
      drain();
    end

    if (mismatches == 0) begin
      $display("** text_console_cursor_writer: PASSED **");
    end else begin
      $display("** text_console_cursor_writer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/tccw_pkg.sv
design/tccw_cursor.sv
design/tccw_seq.sv
design/text_console_cursor_writer.sv
design/tccw_chk.sv
tb/tb_text_console_cursor_writer.sv
